// ----- rtl/core/crca_pkg.sv -----
// Shared types, constants and width helpers of the cropped row/column average core
package crca_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_W     = 8;
    localparam int LINE_W    = 12;
    localparam int AVG_W     = 8;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // queue depths between front end, divider back end and result port
    localparam int JOB_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd4096;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd4096;
    localparam logic [CFG_W-1:0] RST_COL_START    = 13'd0;
    localparam logic [CFG_W-1:0] RST_COL_END      = 13'd4096;
    localparam logic [CFG_W-1:0] RST_ROW_START    = 13'd0;
    localparam logic [CFG_W-1:0] RST_ROW_END      = 13'd4096;

    localparam logic KIND_ROW = 1'b0;
    localparam logic KIND_COL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_COL_START    = 3'd2,
        REG_COL_END      = 3'd3,
        REG_ROW_START    = 3'd4,
        REG_ROW_END      = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        F_CLEAR,
        F_IDLE,
        F_UPDATE
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic              col_emit;
        logic              col_empty;
        logic              row_emit;
        logic              row_empty;
        logic [LINE_W-1:0] col_index;
        logic [LINE_W-1:0] row_index;
    } job_ctrl_t;

    typedef struct packed {
        logic              kind;
        logic [LINE_W-1:0] line_index;
        logic [AVG_W-1:0]  average;
        logic              window_empty;
        logic              last;
    } result_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // sum of one full row or column of pixels
    function automatic int sum_w(input int mw, input int mh);
        return PIX_W + ((idx_w(mw) > idx_w(mh)) ? idx_w(mw) : idx_w(mh));
    endfunction

    // pixel count of a window, up to the full frame size
    function automatic int div_w(input int mw, input int mh);
        return 1 + ((idx_w(mw) > idx_w(mh)) ? idx_w(mw) : idx_w(mh));
    endfunction

endpackage

// ----- rtl/core/crca_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module crca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/crca_fifo.sv -----
// Small register FIFO used for the job queue and the result queue
module crca_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/core/crca_front.sv -----
// Front end: config registers, raster position, row sum and column store update
module crca_front #(
    parameter  int MAX_WIDTH  = crca_pkg::DEF_MAX_WIDTH,
    parameter  int MAX_HEIGHT = crca_pkg::DEF_MAX_HEIGHT,
    localparam int PW = crca_pkg::idx_w(MAX_WIDTH),
    localparam int SW = crca_pkg::sum_w(MAX_WIDTH, MAX_HEIGHT),
    localparam int DW = crca_pkg::div_w(MAX_WIDTH, MAX_HEIGHT)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [crca_pkg::PIX_W-1:0]     pixel,
    input  logic                           frame_start,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [crca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crca_pkg::CFG_W-1:0]     cfg_data,
    output logic                           ram_we,
    output logic [PW-1:0]                  ram_waddr,
    output logic [SW-1:0]                  ram_wdata,
    output logic [PW-1:0]                  ram_raddr,
    input  logic [SW-1:0]                  ram_rdata,
    input  logic                           job_full,
    output logic                           job_push,
    output crca_pkg::job_ctrl_t            job_ctrl,
    output logic [SW-1:0]                  job_col_sum,
    output logic [SW-1:0]                  job_row_sum,
    output logic [DW-1:0]                  job_col_div,
    output logic [DW-1:0]                  job_row_div
);

    import crca_pkg::*;

    localparam int RW  = idx_w(MAX_HEIGHT);
    localparam int KW0 = (PW > RW) ? PW + 1 : RW + 1;
    localparam int KW  = (KW0 > CFG_W) ? KW0 : CFG_W;

    front_state_t state_reg, state_next;

    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [CFG_W-1:0] col_start_reg, col_end_reg, row_start_reg, row_end_reg;

    logic [PW-1:0] col_pos_reg, col_pos_next;
    logic [RW-1:0] row_pos_reg, row_pos_next;
    logic [SW-1:0] row_sum_reg, row_sum_next;
    logic [PW-1:0] clr_cnt_reg, clr_cnt_next;

    // item held over into the store update cycle
    logic [PIX_W-1:0] pix_reg;
    logic [PW-1:0]    col_reg;
    logic             win_reg;
    logic             first_reg;
    job_ctrl_t        ctrl_reg;
    logic [SW-1:0]    rsum_reg;
    logic [DW-1:0]    cdiv_reg, rdiv_reg;

    logic [KW-1:0] w_eff, h_eff, ce_eff, re_eff, cs_k, rs_k, c_k, r_k, r_step;
    logic [PW-1:0] c_pos_in, c_cur;
    logic [RW-1:0] r_pos_in, r_cur;
    logic          take, wrap_col, row_in, col_win, col_first;
    logic          col_ok, col_emit, row_ok, row_emit;
    logic [SW-1:0] rsum_new, col_sum_new;

    assign cfg_ready = 1'b1;
    assign full      = (state_reg != F_IDLE) || job_full;
    assign take      = push && !full;

    // effective frame size and window bounds
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = KW'(1);
        end
        else if (KW'(frame_width_reg) > KW'(MAX_WIDTH))
        begin
            w_eff = KW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = KW'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_eff = KW'(1);
        end
        else if (KW'(frame_height_reg) > KW'(MAX_HEIGHT))
        begin
            h_eff = KW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = KW'(frame_height_reg);
        end

        ce_eff = (KW'(col_end_reg) < w_eff) ? KW'(col_end_reg) : w_eff;
        re_eff = (KW'(row_end_reg) < h_eff) ? KW'(row_end_reg) : h_eff;
        cs_k   = KW'(col_start_reg);
        rs_k   = KW'(row_start_reg);
    end

    // position of the incoming pixel and what it triggers
    always_comb
    begin
        c_pos_in  = frame_start ? '0 : col_pos_reg;
        r_pos_in  = frame_start ? '0 : row_pos_reg;
        wrap_col  = (KW'(c_pos_in) >= w_eff);
        c_cur     = wrap_col ? '0 : c_pos_in;
        r_step    = KW'(r_pos_in) + KW'(wrap_col);
        r_cur     = (r_step >= h_eff) ? '0 : RW'(r_step);
        c_k       = KW'(c_cur);
        r_k       = KW'(r_cur);
        row_in    = (c_k >= cs_k) && (c_k < ce_eff);
        col_win   = (r_k >= rs_k) && (r_k < re_eff);
        col_first = (r_k == rs_k);
        col_ok    = (rs_k < re_eff);
        col_emit  = col_ok ? (r_k == re_eff - 1'b1) : (r_k == h_eff - 1'b1);
        row_ok    = (cs_k < ce_eff);
        row_emit  = (c_k == w_eff - 1'b1);
        rsum_new  = ((c_cur == '0) ? '0 : row_sum_reg) + (row_in ? SW'(pixel) : '0);
    end

    assign col_sum_new = first_reg ? SW'(pix_reg) : ram_rdata + SW'(pix_reg);
    assign ram_raddr   = c_cur;

    always_comb
    begin
        state_next   = state_reg;
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        row_sum_next = row_sum_reg;
        clr_cnt_next = clr_cnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = col_reg;
        ram_wdata    = col_sum_new;
        case (state_reg)
            F_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PW'(MAX_WIDTH - 1))
                begin
                    state_next = F_IDLE;
                end
            end
            F_IDLE:
            begin
                if (take)
                begin
                    state_next = F_UPDATE;
                    if (row_emit)
                    begin
                        col_pos_next = '0;
                        row_pos_next = (r_k >= h_eff - 1'b1) ? '0 : r_cur + 1'b1;
                        row_sum_next = '0;
                    end
                    else
                    begin
                        col_pos_next = c_cur + 1'b1;
                        row_pos_next = r_cur;
                        row_sum_next = rsum_new;
                    end
                end
            end
            F_UPDATE:
            begin
                ram_we     = win_reg;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign job_push    = (state_reg == F_UPDATE);
    assign job_ctrl    = ctrl_reg;
    assign job_col_sum = col_sum_new;
    assign job_row_sum = rsum_reg;
    assign job_col_div = cdiv_reg;
    assign job_row_div = rdiv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= F_CLEAR;
            col_pos_reg      <= '0;
            row_pos_reg      <= '0;
            row_sum_reg      <= '0;
            clr_cnt_reg      <= '0;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            col_start_reg    <= RST_COL_START;
            col_end_reg      <= RST_COL_END;
            row_start_reg    <= RST_ROW_START;
            row_end_reg      <= RST_ROW_END;
        end
        else
        begin
            state_reg   <= state_next;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            row_sum_reg <= row_sum_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    REG_COL_START:    col_start_reg    <= cfg_data;
                    REG_COL_END:      col_end_reg      <= cfg_data;
                    REG_ROW_START:    row_start_reg    <= cfg_data;
                    REG_ROW_END:      row_end_reg      <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg   <= pixel;
            col_reg   <= c_cur;
            win_reg   <= col_win;
            first_reg <= col_first;
            ctrl_reg  <= '{col_emit:  col_emit,
                           col_empty: !col_ok,
                           row_emit:  row_emit,
                           row_empty: !row_ok,
                           col_index: LINE_W'(c_cur),
                           row_index: LINE_W'(r_cur)};
            rsum_reg  <= rsum_new;
            cdiv_reg  <= DW'(re_eff - rs_k);
            rdiv_reg  <= DW'(ce_eff - cs_k);
        end
    end

endmodule

// ----- rtl/core/crca_back.sv -----
// Back end: radix-2 divider shared by column and row averages, result formatting
module crca_back #(
    parameter  int MAX_WIDTH  = crca_pkg::DEF_MAX_WIDTH,
    parameter  int MAX_HEIGHT = crca_pkg::DEF_MAX_HEIGHT,
    localparam int SW = crca_pkg::sum_w(MAX_WIDTH, MAX_HEIGHT),
    localparam int DW = crca_pkg::div_w(MAX_WIDTH, MAX_HEIGHT)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    output logic                job_pop,
    input  crca_pkg::job_ctrl_t job_ctrl,
    input  logic [SW-1:0]       job_col_sum,
    input  logic [SW-1:0]       job_row_sum,
    input  logic [DW-1:0]       job_col_div,
    input  logic [DW-1:0]       job_row_div,
    input  logic                res_full,
    output logic                res_push,
    output crca_pkg::result_t   res
);

    import crca_pkg::*;

    localparam int CW = idx_w(SW);

    back_state_t   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    job_ctrl_t     ctrl_reg, ctrl_next;
    logic          kind_reg, kind_next;
    logic [SW-1:0] row_sum_reg, row_sum_next;
    logic [DW-1:0] row_div_reg, row_div_next;
    logic [DW-1:0] divisor_reg, divisor_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [SW-1:0] quo_reg, quo_next;

    logic [DW:0]   trial, diff;
    logic          ge;
    logic          res_empty;

    assign trial = {rem_reg, quo_reg[SW-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign ge    = (trial >= {1'b0, divisor_reg});

    assign res_empty = (kind_reg == KIND_COL) ? ctrl_reg.col_empty : ctrl_reg.row_empty;

    always_comb
    begin
        res.kind         = kind_reg;
        res.line_index   = (kind_reg == KIND_COL) ? ctrl_reg.col_index : ctrl_reg.row_index;
        res.average      = res_empty ? '0 : quo_reg[AVG_W-1:0];
        res.window_empty = res_empty;
        res.last         = (kind_reg == KIND_ROW) || !ctrl_reg.row_emit;
    end

    assign job_pop  = (state_reg == B_IDLE) && !job_empty;
    assign res_push = (state_reg == B_EMIT) && !res_full;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ctrl_next    = ctrl_reg;
        kind_next    = kind_reg;
        row_sum_next = row_sum_reg;
        row_div_next = row_div_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (job_pop)
                begin
                    ctrl_next    = job_ctrl;
                    row_sum_next = job_row_sum;
                    row_div_next = job_row_div;
                    rem_next     = '0;
                    cnt_next     = CW'(SW - 1);
                    if (job_ctrl.col_emit)
                    begin
                        kind_next    = KIND_COL;
                        quo_next     = job_col_sum;
                        divisor_next = job_col_div;
                        state_next   = B_DIV;
                    end
                    else if (job_ctrl.row_emit)
                    begin
                        kind_next    = KIND_ROW;
                        quo_next     = job_row_sum;
                        divisor_next = job_row_div;
                        state_next   = B_DIV;
                    end
                end
            end
            B_DIV:
            begin
                // one quotient bit per cycle, MSB first
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                quo_next = {quo_reg[SW-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (res_push)
                begin
                    if ((kind_reg == KIND_COL) && ctrl_reg.row_emit)
                    begin
                        kind_next    = KIND_ROW;
                        quo_next     = row_sum_reg;
                        divisor_next = row_div_reg;
                        rem_next     = '0;
                        cnt_next     = CW'(SW - 1);
                        state_next   = B_DIV;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg    <= ctrl_next;
        kind_reg    <= kind_next;
        row_sum_reg <= row_sum_next;
        row_div_reg <= row_div_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

endmodule

// ----- rtl/core/cropped_row_column_average_core.sv -----
// Results: a pixel that closes a column window shows a column result; a second (row)
//   result follows it when the pixel also closes a row.
// Flow: the front end accepts a pixel, then does its column store update before the next;
//   the shared radix-2 divider takes one job at a time, column average before row.
// Reset: rst_n is asynchronous, active low; after release the column store is cleared
//   one entry per cycle, all MAX_WIDTH entries (4096 by default), while full stays high.
module cropped_row_column_average_core #(
    parameter int MAX_WIDTH  = crca_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crca_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // pixel input queue side
    input  logic                           push,
    output logic                           full,
    input  logic [crca_pkg::PIX_W-1:0]     pixel,
    input  logic                           frame_start,
    // result output queue side
    output logic                           empty,
    input  logic                           pop,
    output logic                           kind,
    output logic [crca_pkg::LINE_W-1:0]    line_index,
    output logic [crca_pkg::AVG_W-1:0]     average,
    output logic                           window_empty,
    output logic                           last,
    // register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [crca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crca_pkg::CFG_W-1:0]     cfg_data
);

    import crca_pkg::*;

    localparam int PW    = idx_w(MAX_WIDTH);
    localparam int SW    = sum_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int DW    = div_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int JOB_W = $bits(job_ctrl_t) + 2 * SW + 2 * DW;
    localparam int RES_W = $bits(result_t);

    // Column store port: the front end reads the entry of the incoming column in the
    // accept cycle and writes the updated sum in the cycle after; after reset it sweeps
    // the whole store with zeros.
    logic          ram_we;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [SW-1:0] ram_wdata, ram_rdata;

    // Front end -> job queue. A job carries everything one pixel triggers: which
    // averages to form, their dividends and divisors, and the line numbers.
    logic          fe_push;
    job_ctrl_t     fe_ctrl;
    logic [SW-1:0] fe_col_sum, fe_row_sum;
    logic [DW-1:0] fe_col_div, fe_row_div;

    logic             jq_full, jq_empty, jq_pop;
    logic [JOB_W-1:0] jq_din, jq_dout;
    job_ctrl_t        jq_ctrl;
    logic [SW-1:0]    jq_col_sum, jq_row_sum;
    logic [DW-1:0]    jq_col_div, jq_row_div;

    // Back end -> result queue; the queue decouples the divider from pop.
    logic    be_push, rq_full, rq_empty;
    result_t be_res, rq_head;

    crca_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel       (pixel),
        .frame_start (frame_start),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .job_full    (jq_full),
        .job_push    (fe_push),
        .job_ctrl    (fe_ctrl),
        .job_col_sum (fe_col_sum),
        .job_row_sum (fe_row_sum),
        .job_col_div (fe_col_div),
        .job_row_div (fe_row_div)
    );

    crca_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_col_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign jq_din = {fe_ctrl, fe_col_sum, fe_row_sum, fe_col_div, fe_row_div};

    crca_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .din   (jq_din),
        .full  (jq_full),
        .pop   (jq_pop),
        .dout  (jq_dout),
        .empty (jq_empty)
    );

    assign {jq_ctrl, jq_col_sum, jq_row_sum, jq_col_div, jq_row_div} = jq_dout;

    crca_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_empty   (jq_empty),
        .job_pop     (jq_pop),
        .job_ctrl    (jq_ctrl),
        .job_col_sum (jq_col_sum),
        .job_row_sum (jq_row_sum),
        .job_col_div (jq_col_div),
        .job_row_div (jq_row_div),
        .res_full    (rq_full),
        .res_push    (be_push),
        .res         (be_res)
    );

    crca_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (be_push),
        .din   (be_res),
        .full  (rq_full),
        .pop   (pop),
        .dout  (rq_head),
        .empty (rq_empty)
    );

    // oldest result sits on the ports while empty is low
    assign empty        = rq_empty;
    assign kind         = rq_head.kind;
    assign line_index   = rq_head.line_index;
    assign average      = rq_head.average;
    assign window_empty = rq_head.window_empty;
    assign last         = rq_head.last;

endmodule

// ----- rtl/core/crca_checker.sv -----
// Port-level checker of the cropped row/column average core, bound to the top level
module crca_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic                          kind,
    input logic [crca_pkg::LINE_W-1:0]   line_index,
    input logic [crca_pkg::AVG_W-1:0]    average,
    input logic                          window_empty,
    input logic                          last
);

    import crca_pkg::*;

    // column store sweep keeps the input closed right after reset
    a_full_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> full)
        else $error("input open during column store clear");

    // a row average is always the final result of its pixel
    a_row_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_ROW) |-> last)
        else $error("row result without last");

    a_empty_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && window_empty) |-> (average == '0))
        else $error("empty window with nonzero average");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(line_index)
                              && $stable(average) && $stable(last)))
        else $error("waiting result changed");

endmodule

bind cropped_row_column_average_core crca_checker u_crca_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .line_index   (line_index),
    .average      (average),
    .window_empty (window_empty),
    .last         (last)
);
